[rtl/core/mcfm_pkg.sv]
// Shared types, event codes and the semitone table of the MIDI to FM register mapper.
package mcfm_pkg;

  localparam int FuncW = 3;
  localparam int ChanW = 3;
  localparam int NoteW = 7;
  localparam int LevelW = 7;
  localparam int FreqW = 11;
  localparam int OctW = 4;

  localparam logic [FuncW-1:0] FUNC_NOTE_ON  = 3'd0;
  localparam logic [FuncW-1:0] FUNC_NOTE_OFF = 3'd1;
  localparam logic [FuncW-1:0] FUNC_VOLUME   = 3'd2;
  localparam logic [FuncW-1:0] FUNC_PAN      = 3'd3;
  localparam logic [FuncW-1:0] FUNC_PITCH    = 3'd4;

  localparam logic [1:0] STEREO_LEFT   = 2'd0;
  localparam logic [1:0] STEREO_CENTRE = 2'd1;
  localparam logic [1:0] STEREO_RIGHT  = 2'd2;

  localparam logic [LevelW-1:0] LEVEL_MAX    = 7'h7F;
  localparam logic [LevelW-1:0] PAN_LEFT_MAX = 7'd31;
  localparam logic [LevelW-1:0] PAN_CTR_MAX  = 7'd95;

  // Reciprocal multipliers: 171/2048 stands in for 1/12 on 8-bit values,
  // 5243/2^19 for 1/100 on products up to 68 * 128.
  localparam logic [7:0]  RECIP12  = 8'd171;
  localparam int          RECIP12_SH = 11;
  localparam logic [12:0] RECIP100 = 13'd5243;
  localparam int          RECIP100_SH = 19;
  localparam logic [3:0]  SEMIS    = 4'd12;

  typedef struct packed {
    logic [LevelW-1:0] vol;
    logic [LevelW-1:0] vel;
  } entry_t;

  localparam entry_t ENTRY_RESET = '{vol: LEVEL_MAX, vel: LEVEL_MAX};

  function automatic logic [FreqW-1:0] semitone_freq(input logic [3:0] idx);
    logic [FreqW-1:0] f;
    case (idx)
      4'd0:    f = 11'd607;
      4'd1:    f = 11'd644;
      4'd2:    f = 11'd681;
      4'd3:    f = 11'd722;
      4'd4:    f = 11'd765;
      4'd5:    f = 11'd810;
      4'd6:    f = 11'd858;
      4'd7:    f = 11'd910;
      4'd8:    f = 11'd964;
      4'd9:    f = 11'd1021;
      4'd10:   f = 11'd1081;
      4'd11:   f = 11'd1146;
      4'd12:   f = 11'd1214;
      default: f = 11'd607;
    endcase
    return f;
  endfunction

endpackage

[rtl/core/midi_channel_to_fm_register_mapper.sv]
// Top level of the MIDI channel event to FM register update mapper.
// A result passes through stage one, stage two and the output register to out_valid.
// Throughput: one transaction per cycle; the whole pipeline halts only while a finished
// result waits on a stalled output. The RAM read-modify-write is covered by forwarding.
// Reset (synchronous, rst_n low) empties the pipeline and marks every channel entry
// unwritten; an unwritten entry reads as volume 127 and velocity 127, so no clearing pass.
module midi_channel_to_fm_register_mapper
  import mcfm_pkg::*;
#(
  parameter int CHANNELS      = 6,
  parameter int LOWEST_PITCH  = 11,
  parameter int HIGHEST_PITCH = 106
) (
  input  logic               clk,
  input  logic               rst_n,
  // Input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_func,
  input  logic [2:0]         in_channel,
  input  logic [6:0]         in_note,
  input  logic signed [7:0]  in_detune,
  input  logic [6:0]         in_level,
  // Result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_chan_out,
  output logic               out_set_volume,
  output logic [6:0]         out_volume_out,
  output logic               out_set_pitch,
  output logic [3:0]         out_octave,
  output logic [10:0]        out_freq_number,
  output logic               out_set_stereo,
  output logic [1:0]         out_stereo_mode,
  output logic               out_key_on,
  output logic               out_key_off
);

  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int EW = $bits(entry_t);

  // The whole pipeline moves together; it holds only while a finished result is
  // waiting on a stalled output.
  logic adv;
  logic in_accept;
  assign adv       = !(out_valid && out_stall);
  assign in_stall  = !adv;
  assign in_accept = in_valid && adv;

  // ---------------------------------------------------------------------------
  // Input stage: decide whether the transaction yields a result, split the pitch
  // into octave and semitone index, and take the magnitude of the detune.
  // ---------------------------------------------------------------------------
  logic [7:0]  rel_pitch;
  logic [15:0] oct_prod;
  logic [7:0]  oct_quo;
  logic [7:0]  semi_rem;
  logic        below_low;
  logic        above_high;
  logic        keep;
  logic [7:0]  det_mag;

  always_comb begin
    rel_pitch  = 8'({1'b0, in_note}) - 8'(LOWEST_PITCH);
    oct_prod   = 16'(rel_pitch) * 16'(RECIP12);
    oct_quo    = 8'(oct_prod >> RECIP12_SH);
    semi_rem   = rel_pitch - 8'(oct_quo * 8'(SEMIS));
    below_low  = {1'b0, in_note} < 8'(LOWEST_PITCH);
    above_high = {1'b0, in_note} > 8'(HIGHEST_PITCH);
    keep       = ({2'b00, in_channel} < 5'(CHANNELS)) && (in_func <= FUNC_PITCH) &&
                 !((in_func == FUNC_NOTE_ON) && (below_low || above_high));
    det_mag    = in_detune[7] ? 8'(-in_detune) : 8'(in_detune);
  end

  logic              p1_vld_r;
  logic [2:0]        p1_func_r;
  logic [2:0]        p1_chan_r;
  logic [3:0]        p1_oct_r;
  logic [3:0]        p1_idx_r;
  logic [7:0]        p1_mag_r;
  logic              p1_neg_r;
  logic [6:0]        p1_level_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
    end else if (adv) begin
      p1_vld_r <= in_accept && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_func_r  <= in_func;
      p1_chan_r  <= in_channel;
      p1_oct_r   <= below_low ? 4'd0 : oct_quo[3:0];
      p1_idx_r   <= semi_rem[3:0];
      p1_mag_r   <= det_mag;
      p1_neg_r   <= in_detune[7];
      p1_level_r <= in_level;
    end
  end

  // ---------------------------------------------------------------------------
  // Channel RAM: read on the input transaction, written back from stage one.
  // ---------------------------------------------------------------------------
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] p1_addr;
  entry_t        ram_rdata;
  entry_t        ram_wdata;
  logic          ram_we;
  logic [EW-1:0] ram_rbits;

  assign rd_addr = AW'(in_channel);
  assign p1_addr = AW'(p1_chan_r);

  mcfm_ram #(
    .WIDTH (EW),
    .DEPTH (CHANNELS)
  ) u_chan_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (p1_addr),
    .wdata (ram_wdata),
    .re    (in_accept),
    .raddr (rd_addr),
    .rdata (ram_rbits)
  );

  assign ram_rdata = entry_t'(ram_rbits);

  // One flag per channel says whether its entry was ever written.
  logic [CHANNELS-1:0] written_r;
  // Copy of the write done at the last advancing edge, for a read issued at that edge.
  logic                fwd_vld_r;
  logic [AW-1:0]       fwd_addr_r;
  entry_t              fwd_data_r;

  entry_t      base_entry;
  logic [13:0] vol_prod;
  logic [FreqW-1:0] f_lo;
  logic [FreqW-1:0] f_hi;
  logic [6:0]  f_span;
  logic [13:0] det_prod;

  always_comb begin
    if (fwd_vld_r && (fwd_addr_r == p1_addr)) begin
      base_entry = fwd_data_r;
    end else if (written_r[p1_addr]) begin
      base_entry = ram_rdata;
    end else begin
      base_entry = ENTRY_RESET;
    end
    ram_wdata = base_entry;
    if (p1_func_r == FUNC_VOLUME) begin
      ram_wdata.vol = p1_level_r;
    end
    if (p1_func_r == FUNC_NOTE_ON) begin
      ram_wdata.vel = p1_level_r;
    end
    ram_we   = adv && p1_vld_r &&
               ((p1_func_r == FUNC_NOTE_ON) || (p1_func_r == FUNC_VOLUME));
    vol_prod = 14'(ram_wdata.vol) * 14'(ram_wdata.vel);
    f_lo     = semitone_freq(p1_idx_r);
    f_hi     = semitone_freq(p1_idx_r + 4'd1);
    f_span   = 7'(f_hi - f_lo);
    det_prod = 14'(f_span) * 14'(p1_mag_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r <= '0;
      fwd_vld_r <= 1'b0;
    end else begin
      if (ram_we) begin
        written_r[p1_addr] <= 1'b1;
      end
      if (adv) begin
        fwd_vld_r <= ram_we;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fwd_addr_r <= p1_addr;
      fwd_data_r <= ram_wdata;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage two: the two products are registered before their constant divides.
  // ---------------------------------------------------------------------------
  logic             p2_vld_r;
  logic [2:0]       p2_func_r;
  logic [2:0]       p2_chan_r;
  logic [3:0]       p2_oct_r;
  logic [FreqW-1:0] p2_lo_r;
  logic             p2_neg_r;
  logic [13:0]      p2_det_prod_r;
  logic [13:0]      p2_vol_prod_r;
  logic [6:0]       p2_level_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_vld_r <= 1'b0;
    end else if (adv) begin
      p2_vld_r <= p1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p2_func_r     <= p1_func_r;
      p2_chan_r     <= p1_chan_r;
      p2_oct_r      <= p1_oct_r;
      p2_lo_r       <= f_lo;
      p2_neg_r      <= p1_neg_r;
      p2_det_prod_r <= det_prod;
      p2_vol_prod_r <= vol_prod;
      p2_level_r    <= p1_level_r;
    end
  end

  // Divide by 100 through a reciprocal multiply; divide by 127 from the estimate
  // x >> 7, whose remainder stays below twice 127 and needs one correction.
  logic [26:0]      cents_prod;
  logic [FreqW-1:0] cents_step;
  logic [FreqW-1:0] freq_val;
  logic [6:0]       vq_est;
  logic [7:0]       vq_rem;
  logic [6:0]       vol_val;
  logic [1:0]       stereo_val;

  always_comb begin
    cents_prod = 27'(p2_det_prod_r) * 27'(RECIP100);
    cents_step = FreqW'(cents_prod >> RECIP100_SH);
    freq_val   = p2_neg_r ? (p2_lo_r - cents_step) : (p2_lo_r + cents_step);
    vq_est     = p2_vol_prod_r[13:7];
    vq_rem     = 8'(p2_vol_prod_r[6:0]) + 8'(vq_est);
    vol_val    = (vq_rem >= 8'(LEVEL_MAX)) ? (vq_est + 7'd1) : vq_est;
    if (p2_level_r > PAN_CTR_MAX) begin
      stereo_val = STEREO_RIGHT;
    end else if (p2_level_r > PAN_LEFT_MAX) begin
      stereo_val = STEREO_CENTRE;
    end else begin
      stereo_val = STEREO_LEFT;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: fields not meant for the event kind are zero.
  // ---------------------------------------------------------------------------
  logic        out_vld_r;
  logic [2:0]  out_chan_r;
  logic        out_set_vol_r;
  logic [6:0]  out_vol_r;
  logic        out_set_pitch_r;
  logic [3:0]  out_oct_r;
  logic [10:0] out_freq_r;
  logic        out_set_stereo_r;
  logic [1:0]  out_stereo_r;
  logic        out_key_on_r;
  logic        out_key_off_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= p2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_chan_r       <= p2_chan_r;
      out_set_vol_r    <= 1'b0;
      out_vol_r        <= '0;
      out_set_pitch_r  <= 1'b0;
      out_oct_r        <= '0;
      out_freq_r       <= '0;
      out_set_stereo_r <= 1'b0;
      out_stereo_r     <= '0;
      out_key_on_r     <= 1'b0;
      out_key_off_r    <= 1'b0;
      case (p2_func_r)
        FUNC_NOTE_ON: begin
          out_set_vol_r   <= 1'b1;
          out_vol_r       <= vol_val;
          out_set_pitch_r <= 1'b1;
          out_oct_r       <= p2_oct_r;
          out_freq_r      <= freq_val;
          out_key_on_r    <= 1'b1;
        end
        FUNC_NOTE_OFF: begin
          out_key_off_r <= 1'b1;
        end
        FUNC_VOLUME: begin
          out_set_vol_r <= 1'b1;
          out_vol_r     <= vol_val;
        end
        FUNC_PAN: begin
          out_set_stereo_r <= 1'b1;
          out_stereo_r     <= stereo_val;
        end
        FUNC_PITCH: begin
          out_set_pitch_r <= 1'b1;
          out_oct_r       <= p2_oct_r;
          out_freq_r      <= freq_val;
        end
        default: begin
          out_key_off_r <= 1'b0;
        end
      endcase
    end
  end

  assign out_valid       = out_vld_r;
  assign out_chan_out    = out_chan_r;
  assign out_set_volume  = out_set_vol_r;
  assign out_volume_out  = out_vol_r;
  assign out_set_pitch   = out_set_pitch_r;
  assign out_octave      = out_oct_r;
  assign out_freq_number = out_freq_r;
  assign out_set_stereo  = out_set_stereo_r;
  assign out_stereo_mode = out_stereo_r;
  assign out_key_on      = out_key_on_r;
  assign out_key_off     = out_key_off_r;

`ifndef SYNTHESIS
  // Every delivered transaction carries exactly one kind of update.
  a_one_update: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> $onehot({out_set_stereo_r, out_key_off_r,
                           out_set_vol_r || out_set_pitch_r}))
    else $error("result carries no update or mixed updates");

  // A key on always comes with both the volume and the pitch.
  a_key_on_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_key_on_r |-> out_set_vol_r && out_set_pitch_r)
    else $error("key on without volume and pitch");

  // Every RAM write is recorded for forwarding and marks its channel as written.
  a_write_live: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |=> fwd_vld_r && written_r[fwd_addr_r])
    else $error("channel write not recorded for forwarding");

  // A transaction in stage two reaches the output register on the next advance.
  a_p2_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    p2_vld_r && adv |=> out_vld_r)
    else $error("stage two transaction lost");

  // A stall freezes the whole pipeline, including the forwarding copy.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(p1_vld_r) && $stable(p2_vld_r) && $stable(fwd_vld_r))
    else $error("pipeline moved during a stall");
`endif

endmodule

[rtl/core/mcfm_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module mcfm_ram #(
  parameter int WIDTH = 14,
  parameter int DEPTH = 6,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                   clk,
  input  logic                   we,
  input  logic [AW-1:0]          waddr,
  input  logic [WIDTH-1:0]       wdata,
  input  logic                   re,
  input  logic [AW-1:0]          raddr,
  output logic [WIDTH-1:0]       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[tb/tb_midi_channel_to_fm_register_mapper.sv]
`timescale 1ns / 1ps
// Self-checking testbench of the MIDI to FM register mapper: directed table, then random traffic.
module tb_midi_channel_to_fm_register_mapper
  import mcfm_pkg::*;
;

  // The block is built with its default sizes; the predictor uses the same values.
  localparam int NumChannels = 6;
  localparam int LowestPitch = 11;
  localparam int HighestPitch = 106;

  // Random traffic sends this many events after the directed table, so the whole
  // run drives about 550. It is split into three traffic phases; the last takes the remainder.
  localparam int RandomEvents = 524;
  localparam int PhaseLen = RandomEvents / 3;

  // The one long back-pressure stretch of the receiver, in cycles.
  localparam int HoldCycles = 64;
  // The pipeline is three stages deep, so a handful of cycles after the last
  // update is enough to catch any stray extra transaction.
  localparam int DrainCycles = 8;
  localparam int NumDirected = 26;

  typedef struct packed {
    logic [2:0] func;
    logic [2:0] chan;
    logic [6:0] note;
    logic [7:0] detune;
    logic [6:0] level;
  } midi_event_t;

  typedef struct packed {
    logic [2:0]  chan;
    logic        set_volume;
    logic [6:0]  volume;
    logic        set_pitch;
    logic [3:0]  octave;
    logic [10:0] freq;
    logic        set_stereo;
    logic [1:0]  stereo;
    logic        key_on;
    logic        key_off;
  } fm_update_t;

  // How a directed row gets its expectation: from the predictor, typed in by
  // hand, or typed in as "this event is dropped".
  typedef enum logic [1:0] {ROW_PREDICTED, ROW_GIVEN, ROW_GIVEN_NONE} row_kind_t;

  typedef struct packed {
    midi_event_t ev;
    row_kind_t   kind;
    fm_update_t  upd;
  } stim_row_t;

  // Which side of the handshake is slow, if either.
  typedef enum int {PH_SLOW_SINK, PH_SLOW_SOURCE, PH_STEADY} traffic_phase_t;

  localparam fm_update_t NoUpdate = '0;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  in_func;
  logic [2:0]  in_channel;
  logic [6:0]  in_note;
  logic [7:0]  in_detune;
  logic [6:0]  in_level;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  out_chan_out;
  logic        out_set_volume;
  logic [6:0]  out_volume_out;
  logic        out_set_pitch;
  logic [3:0]  out_octave;
  logic [10:0] out_freq_number;
  logic        out_set_stereo;
  logic [1:0]  out_stereo_mode;
  logic        out_key_on;
  logic        out_key_off;

  // Mirror of the per-channel state of the block.
  logic [6:0] vol_mirror [NumChannels];
  logic [6:0] vel_mirror [NumChannels];

  // FM frequency numbers of one octave of semitones, plus the next octave's root
  // so that interpolation above the last semitone has an upper end.
  int fnum_table [13] = '{607, 644, 681, 722, 765, 810, 858, 910, 964, 1021, 1081, 1146, 1214};

  // Field values that random traffic picks more often than chance would.
  logic [7:0] detune_edges [4] = '{8'h80, 8'h7F, 8'h00, 8'hFF};
  logic [6:0] level_edges [8] = '{7'd0, 7'd1, 7'd31, 7'd32, 7'd95, 7'd96, 7'd126, 7'd127};

  fm_update_t     pending_updates [$];
  traffic_phase_t phase;
  int             failures;
  int             events_sent;
  int             events_dropped;
  int             updates_checked;
  int             updates_by_kind [5];

  // Directed events. Rows whose outcome is plain from the event alone (reset
  // state, extreme pitches and cents, pan thresholds, dropped events) carry the
  // update typed in; the rest rely on the predictor.
  stim_row_t directed_rows [NumDirected] = '{
    // Lowest playable pitch at full velocity straight after reset.
    {{FUNC_NOTE_ON, 3'd0, 7'd11, 8'd0, 7'd127}, ROW_GIVEN,
     {3'd0, 1'b1, 7'd127, 1'b1, 4'd0, 11'd607, 1'b0, 2'b00, 1'b1, 1'b0}},
    // Highest playable pitch, largest upward detune, zero velocity.
    {{FUNC_NOTE_ON, 3'd5, 7'd106, 8'd127, 7'd0}, ROW_GIVEN,
     {3'd5, 1'b1, 7'd0, 1'b1, 4'd7, 11'd1232, 1'b0, 2'b00, 1'b1, 1'b0}},
    // Note on just below and above the playable range, and the top pitch.
    {{FUNC_NOTE_ON, 3'd1, 7'd10, 8'd0, 7'd50}, ROW_GIVEN_NONE, NoUpdate},
    {{FUNC_NOTE_ON, 3'd1, 7'd107, 8'd0, 7'd50}, ROW_GIVEN_NONE, NoUpdate},
    {{FUNC_NOTE_ON, 3'd1, 7'd127, 8'h80, 7'd127}, ROW_GIVEN_NONE, NoUpdate},
    // Note off ignores the pitch entirely.
    {{FUNC_NOTE_OFF, 3'd2, 7'd127, 8'hFF, 7'd127}, ROW_GIVEN,
     {3'd2, 1'b0, 7'd0, 1'b0, 4'd0, 11'd0, 1'b0, 2'b00, 1'b0, 1'b1}},
    // Channel volume at both ends with the reset velocity.
    {{FUNC_VOLUME, 3'd3, 7'd0, 8'd0, 7'd0}, ROW_GIVEN,
     {3'd3, 1'b1, 7'd0, 1'b0, 4'd0, 11'd0, 1'b0, 2'b00, 1'b0, 1'b0}},
    {{FUNC_VOLUME, 3'd3, 7'd0, 8'd0, 7'd127}, ROW_GIVEN,
     {3'd3, 1'b1, 7'd127, 1'b0, 4'd0, 11'd0, 1'b0, 2'b00, 1'b0, 1'b0}},
    // Pan on both sides of each threshold and at the ends.
    {{FUNC_PAN, 3'd4, 7'd0, 8'd0, 7'd0}, ROW_GIVEN,
     {3'd4, 1'b0, 7'd0, 1'b0, 4'd0, 11'd0, 1'b1, STEREO_LEFT, 1'b0, 1'b0}},
    {{FUNC_PAN, 3'd4, 7'd0, 8'd0, 7'd31}, ROW_GIVEN,
     {3'd4, 1'b0, 7'd0, 1'b0, 4'd0, 11'd0, 1'b1, STEREO_LEFT, 1'b0, 1'b0}},
    {{FUNC_PAN, 3'd4, 7'd0, 8'd0, 7'd32}, ROW_GIVEN,
     {3'd4, 1'b0, 7'd0, 1'b0, 4'd0, 11'd0, 1'b1, STEREO_CENTRE, 1'b0, 1'b0}},
    {{FUNC_PAN, 3'd4, 7'd0, 8'd0, 7'd95}, ROW_GIVEN,
     {3'd4, 1'b0, 7'd0, 1'b0, 4'd0, 11'd0, 1'b1, STEREO_CENTRE, 1'b0, 1'b0}},
    {{FUNC_PAN, 3'd4, 7'd0, 8'd0, 7'd96}, ROW_GIVEN,
     {3'd4, 1'b0, 7'd0, 1'b0, 4'd0, 11'd0, 1'b1, STEREO_RIGHT, 1'b0, 1'b0}},
    {{FUNC_PAN, 3'd4, 7'd0, 8'd0, 7'd127}, ROW_GIVEN,
     {3'd4, 1'b0, 7'd0, 1'b0, 4'd0, 11'd0, 1'b1, STEREO_RIGHT, 1'b0, 1'b0}},
    // Pitch change is not range checked: pitch 0 wraps the table index.
    {{FUNC_PITCH, 3'd0, 7'd0, 8'h80, 7'd0}, ROW_GIVEN,
     {3'd0, 1'b0, 7'd0, 1'b1, 4'd0, 11'd749, 1'b0, 2'b00, 1'b0, 1'b0}},
    {{FUNC_PITCH, 3'd0, 7'd127, 8'hFF, 7'd0}, ROW_GIVEN,
     {3'd0, 1'b0, 7'd0, 1'b1, 4'd9, 11'd964, 1'b0, 2'b00, 1'b0, 1'b0}},
    {{FUNC_PITCH, 3'd1, 7'd11, 8'h80, 7'd0}, ROW_GIVEN,
     {3'd1, 1'b0, 7'd0, 1'b1, 4'd0, 11'd560, 1'b0, 2'b00, 1'b0, 1'b0}},
    {{FUNC_PITCH, 3'd1, 7'd10, 8'd50, 7'd0}, ROW_PREDICTED, NoUpdate},
    // Channels past the last FM channel and unknown event kinds are dropped
    // and must leave the channel state alone.
    {{FUNC_NOTE_ON, 3'd6, 7'd60, 8'd0, 7'd0}, ROW_GIVEN_NONE, NoUpdate},
    {{FUNC_VOLUME, 3'd7, 7'd0, 8'd0, 7'd0}, ROW_GIVEN_NONE, NoUpdate},
    {{3'd5, 3'd0, 7'd60, 8'd0, 7'd0}, ROW_GIVEN_NONE, NoUpdate},
    {{3'd7, 3'd0, 7'd60, 8'd0, 7'd0}, ROW_GIVEN_NONE, NoUpdate},
    // Volume and velocity meeting in the scaled volume.
    {{FUNC_VOLUME, 3'd2, 7'd0, 8'd0, 7'd100}, ROW_PREDICTED, NoUpdate},
    {{FUNC_NOTE_ON, 3'd2, 7'd60, 8'hCE, 7'd90}, ROW_PREDICTED, NoUpdate},
    {{FUNC_VOLUME, 3'd5, 7'd0, 8'd0, 7'd1}, ROW_PREDICTED, NoUpdate},
    {{FUNC_NOTE_ON, 3'd5, 7'd60, 8'd1, 7'd1}, ROW_PREDICTED, NoUpdate}
  };

  midi_channel_to_fm_register_mapper #(
    .CHANNELS     (NumChannels),
    .LOWEST_PITCH (LowestPitch),
    .HIGHEST_PITCH(HighestPitch)
  ) i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_channel     (in_channel),
    .in_note        (in_note),
    .in_detune      (in_detune),
    .in_level       (in_level),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_chan_out   (out_chan_out),
    .out_set_volume (out_set_volume),
    .out_volume_out (out_volume_out),
    .out_set_pitch  (out_set_pitch),
    .out_octave     (out_octave),
    .out_freq_number(out_freq_number),
    .out_set_stereo (out_set_stereo),
    .out_stereo_mode(out_stereo_mode),
    .out_key_on     (out_key_on),
    .out_key_off    (out_key_off)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop, in case the run never finishes.
  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Octave of a pitch; everything below the lowest pitch counts as octave 0.
  function automatic logic [3:0] octave_of_note(input logic [6:0] note);
    if (note < LowestPitch) return 4'd0;
    return 4'((int'(note) - LowestPitch) / 12);
  endfunction

  // Frequency number of a pitch bent by signed cents. The semitone index is
  // taken from an 8-bit wrapped distance to the lowest pitch, and the cents
  // scaling truncates toward zero, so negative cents round toward the base.
  function automatic logic [10:0] tuned_freq(input logic [6:0] note, input logic [7:0] cents);
    logic [7:0] rel;
    int idx;
    int base;
    int span;
    rel = {1'b0, note} - 8'(LowestPitch);
    idx = int'(rel) % 12;
    base = fnum_table[idx];
    span = fnum_table[idx + 1] - base;
    if (cents[7]) return 11'(base - (span * (256 - int'(cents))) / 100);
    return 11'(base + (span * int'(cents)) / 100);
  endfunction

  function automatic logic [6:0] scaled_volume(input logic [2:0] ch);
    return 7'((int'(vol_mirror[ch]) * int'(vel_mirror[ch])) / 127);
  endfunction

  // Predicts the FM update an event causes and applies the event to the state
  // mirror. Returns 0 when the block drops the event.
  function automatic bit map_midi_event(input midi_event_t ev, output fm_update_t upd);
    upd = NoUpdate;
    if (ev.chan >= NumChannels || ev.func > FUNC_PITCH) return 1'b0;
    upd.chan = ev.chan;
    case (ev.func)
      FUNC_NOTE_ON: begin
        // An unplayable pitch leaves even the velocity untouched.
        if (ev.note < LowestPitch || ev.note > HighestPitch) return 1'b0;
        vel_mirror[ev.chan] = ev.level;
        upd.set_volume = 1'b1;
        upd.volume = scaled_volume(ev.chan);
        upd.set_pitch = 1'b1;
        upd.octave = octave_of_note(ev.note);
        upd.freq = tuned_freq(ev.note, ev.detune);
        upd.key_on = 1'b1;
      end
      FUNC_NOTE_OFF: begin
        upd.key_off = 1'b1;
      end
      FUNC_VOLUME: begin
        vol_mirror[ev.chan] = ev.level;
        upd.set_volume = 1'b1;
        upd.volume = scaled_volume(ev.chan);
      end
      FUNC_PAN: begin
        upd.set_stereo = 1'b1;
        if (ev.level > PAN_CTR_MAX) upd.stereo = STEREO_RIGHT;
        else if (ev.level > PAN_LEFT_MAX) upd.stereo = STEREO_CENTRE;
        else upd.stereo = STEREO_LEFT;
      end
      default: begin
        upd.set_pitch = 1'b1;
        upd.octave = octave_of_note(ev.note);
        upd.freq = tuned_freq(ev.note, ev.detune);
      end
    endcase
    return 1'b1;
  endfunction

  // Offers one event on the input channel, with random idle cycles first, and
  // records what it should produce once the block takes it. Prediction runs at
  // acceptance so the state mirror sees events in the block's own order.
  task automatic offer_event(input midi_event_t ev, input row_kind_t kind,
                             input fm_update_t given, output bit produced);
    fm_update_t upd;
    int idle_pct;
    idle_pct = (phase == PH_SLOW_SINK) ? 24 : (phase == PH_SLOW_SOURCE) ? 60 : 0;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= ev.func;
    in_channel <= ev.chan;
    in_note <= ev.note;
    in_detune <= ev.detune;
    in_level <= ev.level;
    // The payload holds until an edge sees the stall low.
    do @(posedge clk); while (in_stall);
    events_sent++;
    produced = map_midi_event(ev, upd);
    if (kind == ROW_GIVEN) begin
      produced = 1'b1;
      upd = given;
    end else if (kind == ROW_GIVEN_NONE) begin
      produced = 1'b0;
    end
    if (produced) begin
      pending_updates.push_back(upd);
      updates_by_kind[ev.func]++;
    end else begin
      events_dropped++;
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endtask

  // Receiver side. It stalls at random according to the traffic phase. When
  // the steady phase begins it holds the output off for a long stretch while
  // the sender keeps offering, which fills the pipeline and must push back
  // on the input.
  initial begin
    bit held;
    int stall_pct;
    held = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (phase == PH_STEADY && !held) begin
        held = 1'b1;
        repeat (HoldCycles) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end
      end
      stall_pct = (phase == PH_SLOW_SINK) ? 60 : (phase == PH_SLOW_SOURCE) ? 24 : 0;
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Every update the block hands over is matched against the oldest
  // expectation, field by field.
  always @(posedge clk) begin : check_updates
    fm_update_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_updates.size() == 0) begin
        $error("FM update on channel %0d with no event waiting for one", out_chan_out);
        failures++;
      end else begin
        want = pending_updates.pop_front();
        check_field("chan_out", want.chan, out_chan_out);
        check_field("set_volume", want.set_volume, out_set_volume);
        check_field("volume_out", want.volume, out_volume_out);
        check_field("set_pitch", want.set_pitch, out_set_pitch);
        check_field("octave", want.octave, out_octave);
        check_field("freq_number", want.freq, out_freq_number);
        check_field("set_stereo", want.set_stereo, out_set_stereo);
        check_field("stereo_mode", want.stereo, out_stereo_mode);
        check_field("key_on", want.key_on, out_key_on);
        check_field("key_off", want.key_off, out_key_off);
        updates_checked++;
      end
    end
  end

  // Sender side and run control.
  initial begin
    midi_event_t ev;
    bit produced;
    int made;
    int r;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_func <= '0;
    in_channel <= '0;
    in_note <= '0;
    in_detune <= '0;
    in_level <= '0;
    phase = PH_SLOW_SINK;
    failures = 0;
    events_sent = 0;
    events_dropped = 0;
    updates_checked = 0;
    foreach (updates_by_kind[k]) updates_by_kind[k] = 0;
    // Both per-channel values come out of reset at full scale.
    foreach (vol_mirror[c]) begin
      vol_mirror[c] = LEVEL_MAX;
      vel_mirror[c] = LEVEL_MAX;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      offer_event(directed_rows[i].ev, directed_rows[i].kind, directed_rows[i].upd, produced);

    // Random traffic. Most events are well formed so they reach the state and
    // the arithmetic; a small share addresses missing channels, unknown kinds
    // or unplayable pitches.
    made = 0;
    while (made < RandomEvents) begin
      if (made < PhaseLen) phase = PH_SLOW_SINK;
      else if (made < 2 * PhaseLen) phase = PH_SLOW_SOURCE;
      else phase = PH_STEADY;

      r = $urandom_range(99);
      if (r < 6) ev.func = 3'($urandom_range(7, 5));
      else if (r < 40) ev.func = FUNC_NOTE_ON;
      else if (r < 55) ev.func = FUNC_NOTE_OFF;
      else if (r < 70) ev.func = FUNC_VOLUME;
      else if (r < 82) ev.func = FUNC_PAN;
      else ev.func = FUNC_PITCH;
      ev.chan = ($urandom_range(99) < 8) ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5, 0));
      if (ev.func == FUNC_NOTE_ON && $urandom_range(99) < 85)
        ev.note = 7'($urandom_range(HighestPitch, LowestPitch));
      else
        ev.note = 7'($urandom_range(127, 0));
      ev.detune = ($urandom_range(99) < 15) ? detune_edges[$urandom_range(3, 0)] : 8'($urandom);
      ev.level = ($urandom_range(99) < 20) ? level_edges[$urandom_range(7, 0)] : 7'($urandom);

      offer_event(ev, ROW_PREDICTED, NoUpdate, produced);
      made++;
    end
    in_valid <= 1'b0;

    // Let every expected update arrive, then watch a few more cycles for
    // anything extra.
    while (pending_updates.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Drove %0d MIDI events (%0d dropped by design), checked %0d FM updates.",
             events_sent, events_dropped, updates_checked);
    $display("Updates per event kind: note on %0d, note off %0d, volume %0d, pan %0d, pitch %0d.",
             updates_by_kind[FUNC_NOTE_ON], updates_by_kind[FUNC_NOTE_OFF],
             updates_by_kind[FUNC_VOLUME], updates_by_kind[FUNC_PAN],
             updates_by_kind[FUNC_PITCH]);
    if (failures == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/mcfm_pkg.sv
rtl/core/mcfm_ram.sv
rtl/core/midi_channel_to_fm_register_mapper.sv
tb/tb_midi_channel_to_fm_register_mapper.sv
